[hdl/vn2d_pkg.sv]
// Shared types, constants and byte-blend helpers for the 2D value noise pipeline.
// No dependencies.
package vn2d_pkg;

	localparam int FREQ_W    = 32;
	localparam int SEED_W    = 8;
	localparam int COORD_W   = 16;
	localparam int POS_W     = 24;
	localparam int FRAC_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FREQ_SCALE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_OFFSET = 1'b1;

	localparam logic [FREQ_W-1:0] FREQ_RESET = 32'd65536;
	localparam logic [SEED_W-1:0] SEED_RESET = 8'd0;

	typedef struct packed {
		logic [BYTE_W-1:0] c00;
		logic [BYTE_W-1:0] c10;
		logic [BYTE_W-1:0] c01;
		logic [BYTE_W-1:0] c11;
	} corner_t;

	localparam logic [7:0] PERM_TAB [0:255] = '{
		8'd208, 8'd34,  8'd231, 8'd213, 8'd32,  8'd248, 8'd233, 8'd56,
		8'd161, 8'd78,  8'd24,  8'd140, 8'd71,  8'd48,  8'd140, 8'd254,
		8'd245, 8'd255, 8'd247, 8'd247, 8'd40,  8'd185, 8'd248, 8'd251,
		8'd245, 8'd28,  8'd124, 8'd204, 8'd204, 8'd76,  8'd36,  8'd1,
		8'd107, 8'd28,  8'd234, 8'd163, 8'd202, 8'd224, 8'd245, 8'd128,
		8'd167, 8'd204, 8'd9,   8'd92,  8'd217, 8'd54,  8'd239, 8'd174,
		8'd173, 8'd102, 8'd193, 8'd189, 8'd190, 8'd121, 8'd100, 8'd108,
		8'd167, 8'd44,  8'd43,  8'd77,  8'd180, 8'd204, 8'd8,   8'd81,
		8'd70,  8'd223, 8'd11,  8'd38,  8'd24,  8'd254, 8'd210, 8'd210,
		8'd177, 8'd32,  8'd81,  8'd195, 8'd243, 8'd125, 8'd8,   8'd169,
		8'd112, 8'd32,  8'd97,  8'd53,  8'd195, 8'd13,  8'd203, 8'd9,
		8'd47,  8'd104, 8'd125, 8'd117, 8'd114, 8'd124, 8'd165, 8'd203,
		8'd181, 8'd235, 8'd193, 8'd206, 8'd70,  8'd180, 8'd174, 8'd0,
		8'd167, 8'd181, 8'd41,  8'd164, 8'd30,  8'd116, 8'd127, 8'd198,
		8'd245, 8'd146, 8'd87,  8'd224, 8'd149, 8'd206, 8'd57,  8'd4,
		8'd192, 8'd210, 8'd65,  8'd210, 8'd129, 8'd240, 8'd178, 8'd105,
		8'd228, 8'd108, 8'd245, 8'd148, 8'd140, 8'd40,  8'd35,  8'd195,
		8'd38,  8'd58,  8'd65,  8'd207, 8'd215, 8'd253, 8'd65,  8'd85,
		8'd208, 8'd76,  8'd62,  8'd3,   8'd237, 8'd55,  8'd89,  8'd232,
		8'd50,  8'd217, 8'd64,  8'd244, 8'd157, 8'd199, 8'd121, 8'd252,
		8'd90,  8'd17,  8'd212, 8'd203, 8'd149, 8'd152, 8'd140, 8'd187,
		8'd234, 8'd177, 8'd73,  8'd174, 8'd193, 8'd100, 8'd192, 8'd143,
		8'd97,  8'd53,  8'd145, 8'd135, 8'd19,  8'd103, 8'd13,  8'd90,
		8'd135, 8'd151, 8'd199, 8'd91,  8'd239, 8'd247, 8'd33,  8'd39,
		8'd145, 8'd101, 8'd120, 8'd99,  8'd3,   8'd186, 8'd86,  8'd99,
		8'd41,  8'd237, 8'd203, 8'd111, 8'd79,  8'd220, 8'd135, 8'd158,
		8'd42,  8'd30,  8'd154, 8'd120, 8'd67,  8'd87,  8'd167, 8'd135,
		8'd176, 8'd183, 8'd191, 8'd253, 8'd115, 8'd184, 8'd21,  8'd233,
		8'd58,  8'd129, 8'd233, 8'd142, 8'd39,  8'd128, 8'd211, 8'd118,
		8'd137, 8'd139, 8'd255, 8'd114, 8'd20,  8'd218, 8'd113, 8'd154,
		8'd27,  8'd127, 8'd246, 8'd250, 8'd1,   8'd8,   8'd198, 8'd250,
		8'd209, 8'd92,  8'd222, 8'd173, 8'd21,  8'd88,  8'd102, 8'd219
	};

	function automatic logic [BYTE_W-1:0] scale_byte(input logic [BYTE_W-1:0] d,
		input logic [BYTE_W-1:0] k);
		logic [16:0] p;
		p = 17'(d) * 17'({1'b0, k} + 9'd1);
		return p[15:8];
	endfunction

	function automatic logic [BYTE_W-1:0] lerp_byte(input logic [BYTE_W-1:0] p,
		input logic [BYTE_W-1:0] q, input logic [BYTE_W-1:0] k);
		if (q > p) begin
			return p + scale_byte(q - p, k);
		end
		return p - scale_byte(p - q, k);
	endfunction

	function automatic logic [BYTE_W-1:0] smooth_blend(input logic [BYTE_W-1:0] a,
		input logic [BYTE_W-1:0] b, input logic [BYTE_W-1:0] w8);
		if (a > b) begin
			return lerp_byte(a, b, w8);
		end
		return lerp_byte(b, a, 8'hFF - w8);
	endfunction

endpackage

[hdl/vn2d_lattice.sv]
// Two-stage lattice hash: y row lookups with seed, then the four corner lookups.
// Depends on vn2d_pkg (permutation table, corner_t).
module vn2d_lattice (
	input  logic                        clk,
	input  logic [vn2d_pkg::BYTE_W-1:0] xi_s1,
	input  logic [vn2d_pkg::BYTE_W-1:0] yi_s1,
	input  logic [vn2d_pkg::SEED_W-1:0] seed,
	output vn2d_pkg::corner_t           corner_s3
);

	logic [vn2d_pkg::BYTE_W-1:0] row0_s2;
	logic [vn2d_pkg::BYTE_W-1:0] row1_s2;
	logic [vn2d_pkg::BYTE_W-1:0] xi_s2;
	logic [vn2d_pkg::BYTE_W-1:0] ya;
	logic [vn2d_pkg::BYTE_W-1:0] yb;
	logic [vn2d_pkg::BYTE_W-1:0] xa;

	assign ya = yi_s1 + seed;
	assign yb = yi_s1 + seed + 8'd1;
	assign xa = xi_s2 + 8'd1;

	always_ff @(posedge clk) begin
		row0_s2 <= vn2d_pkg::PERM_TAB[ya];
		row1_s2 <= vn2d_pkg::PERM_TAB[yb];
		xi_s2   <= xi_s1;
	end

	always_ff @(posedge clk) begin
		corner_s3.c00 <= vn2d_pkg::PERM_TAB[8'(row0_s2 + xi_s2)];
		corner_s3.c10 <= vn2d_pkg::PERM_TAB[8'(row0_s2 + xa)];
		corner_s3.c01 <= vn2d_pkg::PERM_TAB[8'(row1_s2 + xi_s2)];
		corner_s3.c11 <= vn2d_pkg::PERM_TAB[8'(row1_s2 + xa)];
	end

endmodule

[hdl/vn2d_weight.sv]
// Two-stage smoothstep weight s*s*(3-2s) on a Q16 fraction, reduced to 8 bits.
// Depends on vn2d_pkg (widths).
module vn2d_weight (
	input  logic                        clk,
	input  logic [vn2d_pkg::FRAC_W-1:0] frac_s1,
	output logic [vn2d_pkg::BYTE_W-1:0] w8_s3
);

	localparam logic [17:0] THREE_Q16 = 18'd196608;

	logic [31:0]                 sq_s2;
	logic [vn2d_pkg::FRAC_W-1:0] frac_s2;
	logic [17:0]                 tail;
	logic [49:0]                 prod;

	assign tail = THREE_Q16 - {1'b0, frac_s2, 1'b0};
	assign prod = 50'(sq_s2) * 50'(tail);

	always_ff @(posedge clk) begin
		sq_s2   <= 32'(frac_s1) * 32'(frac_s1);
		frac_s2 <= frac_s1;
		w8_s3   <= prod[47:40];
	end

endmodule

[hdl/vn2d_blend.sv]
// Two-stage corner blend: along x for both rows, then along y.
// Depends on vn2d_pkg (corner_t, smooth_blend).
module vn2d_blend (
	input  logic                        clk,
	input  vn2d_pkg::corner_t           corner_s3,
	input  logic [vn2d_pkg::BYTE_W-1:0] wx_s3,
	input  logic [vn2d_pkg::BYTE_W-1:0] wy_s3,
	output logic [vn2d_pkg::BYTE_W-1:0] noise_s5
);

	logic [vn2d_pkg::BYTE_W-1:0] lo_s4;
	logic [vn2d_pkg::BYTE_W-1:0] hi_s4;
	logic [vn2d_pkg::BYTE_W-1:0] wy_s4;

	always_ff @(posedge clk) begin
		lo_s4    <= vn2d_pkg::smooth_blend(corner_s3.c00, corner_s3.c10, wx_s3);
		hi_s4    <= vn2d_pkg::smooth_blend(corner_s3.c01, corner_s3.c11, wx_s3);
		wy_s4    <= wy_s3;
		noise_s5 <= vn2d_pkg::smooth_blend(lo_s4, hi_s4, wy_s4);
	end

endmodule

[hdl/value_noise_2d_generator.sv]
// 2D value noise generator: top level with configuration registers and scaling stage.
// Depends on vn2d_pkg, vn2d_lattice, vn2d_weight, vn2d_blend.
//
// Takes one coordinate pair per cycle (busy never rises) and returns each noise value
// marked by a one-cycle done strobe. Each value passes five register stages: coordinate
// scaling, row hash, corner hash with weight product, x blend, y blend. The receiver
// cannot stall, so results leave in input order on a fixed schedule. Write freq_scale
// and seed_offset only while idle.
module value_noise_2d_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic signed [vn2d_pkg::COORD_W-1:0] x_coord,
	input  logic signed [vn2d_pkg::COORD_W-1:0] y_coord,
	input  logic                           wr_en,
	input  logic [vn2d_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [vn2d_pkg::FREQ_W-1:0]    wr_data,
	output logic                           done,
	output logic [vn2d_pkg::BYTE_W-1:0]    noise_value
);

	logic [vn2d_pkg::FREQ_W-1:0] freq_q;
	logic [vn2d_pkg::SEED_W-1:0] seed_q;

	logic [4:0] valid_q;

	logic [2*vn2d_pkg::POS_W-1:0] prod_x;
	logic [2*vn2d_pkg::POS_W-1:0] prod_y;
	logic [vn2d_pkg::POS_W-1:0]   px_s1;
	logic [vn2d_pkg::POS_W-1:0]   py_s1;

	vn2d_pkg::corner_t           corner_s3;
	logic [vn2d_pkg::BYTE_W-1:0] wx_s3;
	logic [vn2d_pkg::BYTE_W-1:0] wy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= vn2d_pkg::FREQ_RESET;
			seed_q <= vn2d_pkg::SEED_RESET;
		end else if (wr_en) begin
			case (wr_index)
				vn2d_pkg::REG_FREQ_SCALE:  freq_q <= wr_data;
				vn2d_pkg::REG_SEED_OFFSET: seed_q <= wr_data[vn2d_pkg::SEED_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[3:0], start & ~busy};
		end
	end

	// only the low 24 product bits reach the lattice index and fraction
	assign prod_x = 48'({{(vn2d_pkg::POS_W-vn2d_pkg::COORD_W){x_coord[15]}}, x_coord})
		* 48'(freq_q[vn2d_pkg::POS_W-1:0]);
	assign prod_y = 48'({{(vn2d_pkg::POS_W-vn2d_pkg::COORD_W){y_coord[15]}}, y_coord})
		* 48'(freq_q[vn2d_pkg::POS_W-1:0]);

	always_ff @(posedge clk) begin
		px_s1 <= prod_x[vn2d_pkg::POS_W-1:0];
		py_s1 <= prod_y[vn2d_pkg::POS_W-1:0];
	end

	vn2d_lattice u_lattice (
		.clk       (clk),
		.xi_s1     (px_s1[23:16]),
		.yi_s1     (py_s1[23:16]),
		.seed      (seed_q),
		.corner_s3 (corner_s3)
	);

	vn2d_weight u_weight_x (
		.clk     (clk),
		.frac_s1 (px_s1[15:0]),
		.w8_s3   (wx_s3)
	);

	vn2d_weight u_weight_y (
		.clk     (clk),
		.frac_s1 (py_s1[15:0]),
		.w8_s3   (wy_s3)
	);

	vn2d_blend u_blend (
		.clk       (clk),
		.corner_s3 (corner_s3),
		.wx_s3     (wx_s3),
		.wy_s3     (wy_s3),
		.noise_s5  (noise_value)
	);

	assign done = valid_q[4];

endmodule
